FILE: src/mhp_pkg.sv
package mhp_pkg;

  // Hull storage and data widths
  localparam int unsigned DepthDef = 1024;
  localparam int unsigned SumW     = 18;
  localparam int unsigned SlopeW   = 31;
  localparam int unsigned IntW     = 64;
  localparam int unsigned EntryW   = SlopeW + IntW;
  localparam int unsigned AW       = 11;
  localparam int unsigned BW       = 32;
  localparam int unsigned CW       = 32;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned MulW     = 34;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned DiffW    = IntW + 1;
  localparam int unsigned CmpW     = 98;
  localparam logic [SumW-1:0] SumMax = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegCoefA = 2'd0,
    RegCoefB = 2'd1,
    RegCoefC = 2'd2,
    RegNone  = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [19:0] {
    StIdle  = 20'h00001,
    StF1    = 20'h00002,
    StF2    = 20'h00004,
    StF3    = 20'h00008,
    StF4    = 20'h00010,
    StQRd   = 20'h00020,
    StQMul  = 20'h00040,
    StQCmp  = 20'h00080,
    StEvRd  = 20'h00100,
    StEvMul = 20'h00200,
    StEvAdd = 20'h00400,
    StPChk  = 20'h00800,
    StPTop  = 20'h01000,
    StPM0   = 20'h02000,
    StPM1   = 20'h04000,
    StPM2   = 20'h08000,
    StPM3   = 20'h10000,
    StPCmp  = 20'h20000,
    StPWr   = 20'h40000,
    StDone  = 20'h80000
  } state_e;

endpackage

FILE: src/monotone_hull_partition_dp.sv
// Time from accept to result depends on the hull size and grows with each pointer advance,
// each equal-slope pop and each breakpoint pop, plus output stalls.
// Throughput: one item at a time, accepted the cycle after the previous result is
// registered.
// Reset: coefficients return to a=-1, b=0, c=0; sum, hull count and pointer clear.
// The hull memory holds no reset and needs no clearing pass.
module monotone_hull_partition_dp #(
  parameter int unsigned DEPTH = mhp_pkg::DepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     value_i,
  input  logic                           start_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [63:0]             best_total_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mhp_pkg::AddrW-1:0]      paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mhp_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IW:0] DepthC = (IW + 1)'(DEPTH);

  state_e state_q, state_d;

  logic signed [AW-1:0]     a_q;
  logic signed [BW-1:0]     b_q;
  logic signed [CW-1:0]     c_q;
  logic [SumW-1:0]          sum_q, sum_d, p_q, p_d;
  logic [IW:0]              count_q, count_d;
  logic [IW-1:0]            qp_q, qp_d;
  logic signed [ProdW-1:0]  mul_q;
  logic signed [MulW-1:0]   mul_x, mul_y;
  logic signed [SlopeW-1:0] m_q, m_d;
  logic [IntW-1:0]          app_q, app_d, bp_q, bp_d, fp_q, fp_d;
  logic [IntW-1:0]          score_q, score_d, bnew_q, bnew_d, evi_q, evi_d;
  logic signed [CmpW-1:0]   acc_q, acc_d, racc_q, racc_d;
  logic signed [DiffW-1:0]  x1_q, x1_d, x2_q, x2_d;
  logic [31:0]              dprev_q, dprev_d, dnew_q, dnew_d;
  logic                     out_valid_q;
  logic [IntW-1:0]          out_q;

  logic                     we;
  logic [IW-1:0]            ra0, ra1;
  logic [EntryW-1:0]        rd0, rd1;

  logic                     in_acc, cfg_wr;
  reg_idx_e                 cfg_idx;

  // Hull storage
  mhp_hull_mem #(.DEPTH(DEPTH), .IW(IW)) u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (count_q[IW-1:0]),
    .wdata_i  ({m_q, bnew_q}),
    .raddr0_i (ra0),
    .raddr1_i (ra1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      RegCoefA: prdata = 32'(a_q);
      RegCoefB: prdata = b_q;
      RegCoefC: prdata = c_q;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= -11'sd1;
      b_q <= '0;
      c_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegCoefA: a_q <= pwdata[AW-1:0];
        RegCoefB: b_q <= pwdata;
        RegCoefC: c_q <= pwdata;
        default:  ;
      endcase
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign in_acc       = in_valid_i & ~in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign best_total_o = out_q;

  // Shared multiplier, registered
  always_ff @(posedge clk_i) begin
    mul_q <= mul_x * mul_y;
  end

  // Sequencer
  always_comb begin
    logic [SumW:0]           sum_w;
    logic [IntW-1:0]         fp_w, cand_w, sc_w;
    logic signed [SlopeW-1:0] ts, ps;
    logic [IntW-1:0]         ti, pi;
    logic signed [CmpW-1:0]  rhs_w;
    logic [IW-1:0]           qpc;

    state_d = state_q;
    sum_d = sum_q;   p_d = p_q;   count_d = count_q; qp_d = qp_q;
    m_d = m_q;       app_d = app_q; bp_d = bp_q; fp_d = fp_q;
    score_d = score_q; bnew_d = bnew_q; evi_d = evi_q;
    acc_d = acc_q;   racc_d = racc_q; x1_d = x1_q; x2_d = x2_q;
    dprev_d = dprev_q; dnew_d = dnew_q;
    mul_x = '0;  mul_y = '0;  we = 1'b0;
    ra0 = qp_q;  ra1 = qp_q + IW'(1);

    sum_w  = '0;
    fp_w   = app_q + mul_q[IntW-1:0] + IntW'(c_q);
    cand_w = mul_q[IntW-1:0] + evi_q + fp_q;
    sc_w   = ($signed(cand_w) > $signed(fp_q)) ? cand_w : fp_q;
    ts     = rd0[EntryW-1:IntW];
    ti     = rd0[IntW-1:0];
    ps     = rd1[EntryW-1:IntW];
    pi     = rd1[IntW-1:0];
    rhs_w  = racc_q + CmpW'(mul_q);
    qpc    = (IW + 1)'(qp_q) > (count_q - (IW + 1)'(1)) ?
             IW'(count_q - (IW + 1)'(1)) : qp_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          // clear on start, then add with saturation
          sum_w = {1'b0, (start_req_i ? SumW'(0) : sum_q)} + (SumW + 1)'(value_i);
          sum_d = sum_w[SumW] ? SumMax : sum_w[SumW-1:0];
          p_d   = sum_d;
          if (start_req_i) begin
            count_d = '0;
            qp_d    = '0;
          end
          state_d = StF1;
        end
      end
      StF1: begin
        mul_x = MulW'(a_q);
        mul_y = MulW'({1'b0, p_q});
        state_d = StF2;
      end
      StF2: begin
        mul_x = mul_q[MulW-1:0];
        mul_y = MulW'({1'b0, p_q});
        m_d   = SlopeW'(0) - {mul_q[SlopeW-2:0], 1'b0};
        state_d = StF3;
      end
      StF3: begin
        app_d = mul_q[IntW-1:0];
        mul_x = MulW'(b_q);
        mul_y = MulW'({1'b0, p_q});
        state_d = StF4;
      end
      StF4: begin
        bp_d = mul_q[IntW-1:0];
        fp_d = fp_w;
        if (count_q == '0) begin
          score_d = fp_w;
          bnew_d  = app_q - mul_q[IntW-1:0] + fp_w;
          state_d = StPChk;
        end else begin
          qp_d = qpc;
          if ((IW + 1)'(qpc) < count_q - (IW + 1)'(1)) state_d = StQRd;
          else state_d = StEvRd;
        end
      end
      StQRd: begin
        state_d = StQMul;
      end
      StQMul: begin
        // p times slope step against intercept step
        mul_x = MulW'({1'b0, p_q});
        mul_y = MulW'({1'b0, 32'(32'(ps) - 32'(ts))});
        acc_d = CmpW'($signed(rd0[IntW-1:0])) - CmpW'($signed(rd1[IntW-1:0]));
        state_d = StQCmp;
      end
      StQCmp: begin
        if (acc_q < CmpW'(mul_q)) begin
          qp_d = qp_q + IW'(1);
          if ((IW + 1)'(qp_q) + (IW + 1)'(1) < count_q - (IW + 1)'(1)) state_d = StQRd;
          else state_d = StEvRd;
        end else begin
          state_d = StEvRd;
        end
      end
      StEvRd: begin
        state_d = StEvMul;
      end
      StEvMul: begin
        mul_x = MulW'(ts);
        mul_y = MulW'({1'b0, p_q});
        evi_d = ti;
        state_d = StEvAdd;
      end
      StEvAdd: begin
        score_d = sc_w;
        bnew_d  = app_q - bp_q + sc_w;
        state_d = StPChk;
      end
      StPChk: begin
        ra0 = IW'(count_q - (IW + 1)'(1));
        ra1 = IW'(count_q - (IW + 1)'(2));
        if (count_q == '0) state_d = StPWr;
        else state_d = StPTop;
      end
      StPTop: begin
        priority if (m_q < ts) begin
          state_d = StDone;
        end else if (m_q == ts) begin
          if ($signed(bnew_q) > $signed(ti)) begin
            count_d = count_q - (IW + 1)'(1);
            state_d = StPChk;
          end else begin
            state_d = StDone;
          end
        end else if (count_q >= (IW + 1)'(2)) begin
          x1_d    = DiffW'($signed(ti)) - DiffW'($signed(bnew_q));
          x2_d    = DiffW'($signed(pi)) - DiffW'($signed(ti));
          dprev_d = 32'(ts) - 32'(ps);
          dnew_d  = 32'(m_q) - 32'(ts);
          state_d = StPM0;
        end else begin
          state_d = StPWr;
        end
      end
      StPM0: begin
        mul_x = MulW'($signed(x1_q[DiffW-1:32]));
        mul_y = MulW'({1'b0, dprev_q});
        state_d = StPM1;
      end
      StPM1: begin
        mul_x = MulW'({1'b0, x1_q[31:0]});
        mul_y = MulW'({1'b0, dprev_q});
        acc_d = CmpW'(mul_q) <<< 32;
        state_d = StPM2;
      end
      StPM2: begin
        mul_x = MulW'($signed(x2_q[DiffW-1:32]));
        mul_y = MulW'({1'b0, dnew_q});
        acc_d = acc_q + CmpW'(mul_q);
        state_d = StPM3;
      end
      StPM3: begin
        mul_x = MulW'({1'b0, x2_q[31:0]});
        mul_y = MulW'({1'b0, dnew_q});
        racc_d = CmpW'(mul_q) <<< 32;
        state_d = StPCmp;
      end
      StPCmp: begin
        if (acc_q <= rhs_w) begin
          count_d = count_q - (IW + 1)'(1);
          state_d = StPChk;
        end else begin
          state_d = StPWr;
        end
      end
      StPWr: begin
        if (count_q < DepthC) begin
          we      = 1'b1;
          count_d = count_q + (IW + 1)'(1);
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sum_q       <= '0;
      count_q     <= '0;
      qp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      qp_q    <= qp_d;
      if (state_q == StDone && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= p_d;     m_q <= m_d;     app_q <= app_d; bp_q <= bp_d;
    fp_q <= fp_d;   score_q <= score_d; bnew_q <= bnew_d; evi_q <= evi_d;
    acc_q <= acc_d; racc_q <= racc_d; x1_q <= x1_d; x2_q <= x2_d;
    dprev_q <= dprev_d; dnew_q <= dnew_d;
    if (state_q == StDone && (!out_valid_q || !out_stall_i)) begin
      out_q <= score_q;
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("hull count beyond depth");
  a_ptr_in_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEvRd |-> (IW + 1)'(qp_q) < count_q) else $error("pointer beyond hull");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPWr && count_q < DepthC) |=> count_q == $past(count_q) + (IW + 1)'(1))
    else $error("push lost");

endmodule

FILE: src/mhp_hull_mem.sv
module mhp_hull_mem #(
  parameter int unsigned DEPTH = mhp_pkg::DepthDef,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [IW-1:0]               waddr_i,
  input  logic [mhp_pkg::EntryW-1:0]  wdata_i,
  input  logic [IW-1:0]               raddr0_i,
  input  logic [IW-1:0]               raddr1_i,
  output logic [mhp_pkg::EntryW-1:0]  rdata0_o,
  output logic [mhp_pkg::EntryW-1:0]  rdata1_o
);
  import mhp_pkg::*;

  logic [EntryW-1:0] mem [DEPTH];

  // Write one line per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read two lines, registered
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule
